FILE: rtl/aff2d_pkg.sv
`timescale 1ns / 1ps
// Package for the 2D affine transform accumulator.
// Opcode codes, internal command type and the request/result payload structs.
// No dependencies.
package aff2d_pkg;

    localparam logic [2:0] OPC_IDENT = 3'd0;
    localparam logic [2:0] OPC_SCALE = 3'd1;
    localparam logic [2:0] OPC_ROT   = 3'd2;
    localparam logic [2:0] OPC_TRANS = 3'd3;
    localparam logic [2:0] OPC_POINT = 3'd4;

    typedef enum logic [2:0] {
        OP_IDENT,
        OP_SCALE,
        OP_ROT,
        OP_TRANS,
        OP_POINT
    } t_op;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
    } t_cmd;

endpackage

FILE: rtl/affine_2d_transform_accumulator_top.sv
`timescale 1ns / 1ps
// Top level of the 2D affine transform accumulator.
// Depends on aff2d_pkg, aff2d_front, aff2d_queue and aff2d_back.
//
// Usage:
//   Requests enter on i_in_valid/o_in_ready with i_in_item (opcode plus two
//   Q16.16 vectors). Opcodes identity, scale, rotate and translate update the
//   stored matrix and give no result; transform point gives one result on
//   o_out_valid/i_out_ready with o_out_item. Opcodes 5 to 7 are taken and
//   dropped.
//   A point request is written into the queue, then popped by the execute
//   stage into the result register, which raises o_out_valid. Throughput:
//   one request per cycle sustained while results are taken; each matrix
//   update is one multiply-add pass of the execute stage, which sets the rate.
//   A request queue of QUEUE_DEPTH entries sits between decode and execute;
//   when the receiver stalls, the result register holds, point requests wait
//   in the queue and o_in_ready drops once the queue is full.
//   Reset (i_rst_n low, synchronous) empties the queue and result register and
//   sets the matrix to identity.
module affine_2d_transform_accumulator_top #(
    parameter int WORD_BITS   = 32,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  aff2d_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output aff2d_pkg::t_out_item o_out_item
);

    logic            push_valid, push_ready;
    aff2d_pkg::t_cmd push_cmd;
    logic            head_valid, head_pop;
    aff2d_pkg::t_cmd head_cmd;

    aff2d_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    aff2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_head_valid (head_valid),
        .i_pop        (head_pop),
        .o_head_cmd   (head_cmd)
    );

    aff2d_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .o_cmd_pop   (head_pop),
        .i_cmd       (head_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // a held result blocks the next point
    a_point_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (head_valid && head_cmd.op == aff2d_pkg::OP_POINT && o_out_valid && !i_out_ready)
        |-> !head_pop)
        else $error("point issued over a stalled result");

    a_point_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (head_pop && head_cmd.op == aff2d_pkg::OP_POINT) |=> o_out_valid)
        else $error("issued point produced no result");

    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && (i_in_item.opcode > aff2d_pkg::OPC_POINT)) |-> !push_valid)
        else $error("unused opcode entered the queue");

    a_no_phantom_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_pop |-> head_valid)
        else $error("execute popped an empty queue");

endmodule

FILE: rtl/aff2d_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the opcode and drops unused codes.
// Depends on aff2d_pkg.
module aff2d_front (
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  aff2d_pkg::t_in_item i_in_item,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output aff2d_pkg::t_cmd     o_push_cmd
);

    logic known;

    always_comb begin
        known           = 1'b1;
        o_push_cmd.op   = aff2d_pkg::OP_IDENT;
        o_push_cmd.a_x  = i_in_item.a_x;
        o_push_cmd.a_y  = i_in_item.a_y;
        o_push_cmd.b_x  = i_in_item.b_x;
        o_push_cmd.b_y  = i_in_item.b_y;
        case (i_in_item.opcode)
            aff2d_pkg::OPC_IDENT: o_push_cmd.op = aff2d_pkg::OP_IDENT;
            aff2d_pkg::OPC_SCALE: o_push_cmd.op = aff2d_pkg::OP_SCALE;
            aff2d_pkg::OPC_ROT:   o_push_cmd.op = aff2d_pkg::OP_ROT;
            aff2d_pkg::OPC_TRANS: o_push_cmd.op = aff2d_pkg::OP_TRANS;
            aff2d_pkg::OPC_POINT: o_push_cmd.op = aff2d_pkg::OP_POINT;
            default:              known = 1'b0;
        endcase
    end

    // unused opcodes are taken and discarded
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid && known;

endmodule

FILE: rtl/aff2d_queue.sv
`timescale 1ns / 1ps
// Small command FIFO between the front end and the execute stage.
// Depends on aff2d_pkg.
module aff2d_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  aff2d_pkg::t_cmd i_push_cmd,
    output logic            o_head_valid,
    input  logic            i_pop,
    output aff2d_pkg::t_cmd o_head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aff2d_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_cmd   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: rtl/aff2d_back.sv
`timescale 1ns / 1ps
// Execute stage: holds the six matrix words, applies updates, transforms points
// into a registered result. Depends on aff2d_pkg.
module aff2d_back #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_pop,
    input  aff2d_pkg::t_cmd      i_cmd,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output aff2d_pkg::t_out_item o_out_item
);

    localparam int SW        = 2 * WORD_BITS + 2;
    localparam int NUM_WORDS = 6;

    localparam logic signed [SW-1:0] ONE_S = SW'(1);
    localparam logic signed [SW-1:0] HI_W  = (ONE_S <<< (WORD_BITS - 1)) - ONE_S;
    localparam logic signed [SW-1:0] LO_W  = -HI_W - ONE_S;
    localparam logic signed [SW-1:0] HI_32 = (ONE_S <<< 31) - ONE_S;
    localparam logic signed [SW-1:0] LO_32 = -HI_32 - ONE_S;
    localparam logic signed [SW-1:0] RND   = (ONE_S <<< FRAC_BITS) - ONE_S;
    localparam logic signed [SW-1:0] ONE_Q = ONE_S <<< FRAC_BITS;
    localparam logic signed [SW-1:0] ONE_M = (ONE_Q > HI_W) ? HI_W : ONE_Q;
    localparam logic signed [WORD_BITS-1:0] ONE_W = ONE_M[WORD_BITS-1:0];

    function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v;
        if (v > HI_W) begin
            r = HI_W;
        end else if (v < LO_W) begin
            r = LO_W;
        end
        return r[WORD_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] sat_32(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v;
        if (v > HI_32) begin
            r = HI_32;
        end else if (v < LO_32) begin
            r = LO_32;
        end
        return r[31:0];
    endfunction

    // exact product, truncated toward zero, saturated
    function automatic logic signed [WORD_BITS-1:0] mulq(input logic signed [WORD_BITS-1:0] a,
                                                         input logic signed [WORD_BITS-1:0] b);
        logic signed [SW-1:0] p;
        p = SW'(a) * SW'(b);
        if (p[SW-1]) begin
            p = p + RND;
        end
        return sat_w(p >>> FRAC_BITS);
    endfunction

    logic signed [WORD_BITS-1:0] r_m [NUM_WORDS];
    logic signed [WORD_BITS-1:0] n_m [NUM_WORDS];
    logic signed [WORD_BITS-1:0] ax, ay, bx, by;
    logic signed [WORD_BITS-1:0] px, py;
    logic                        r_out_valid, n_out_valid;
    aff2d_pkg::t_out_item        r_out, n_out;
    logic                        out_free, is_point;

    assign ax = sat_w(SW'(i_cmd.a_x));
    assign ay = sat_w(SW'(i_cmd.a_y));
    assign bx = sat_w(SW'(i_cmd.b_x));
    assign by = sat_w(SW'(i_cmd.b_y));

    assign is_point  = (i_cmd.op == aff2d_pkg::OP_POINT);
    assign out_free  = !r_out_valid || i_out_ready;
    assign o_cmd_pop = i_cmd_valid && (!is_point || out_free);

    assign px = sat_w(SW'(mulq(ax, r_m[0])) + SW'(mulq(ay, r_m[2])) + SW'(r_m[4]));
    assign py = sat_w(SW'(mulq(ax, r_m[1])) + SW'(mulq(ay, r_m[3])) + SW'(r_m[5]));

    always_comb begin
        n_m = r_m;
        case (i_cmd.op)
            aff2d_pkg::OP_IDENT: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    n_m[i] = '0;
                end
                n_m[0] = ONE_W;
                n_m[3] = ONE_W;
            end
            aff2d_pkg::OP_SCALE: begin
                for (int r = 0; r < 3; r++) begin
                    n_m[2*r]   = mulq(r_m[2*r], ax);
                    n_m[2*r+1] = mulq(r_m[2*r+1], ay);
                end
            end
            aff2d_pkg::OP_ROT: begin
                for (int r = 0; r < 3; r++) begin
                    n_m[2*r]   = sat_w(SW'(mulq(r_m[2*r], ax)) + SW'(mulq(r_m[2*r+1], bx)));
                    n_m[2*r+1] = sat_w(SW'(mulq(r_m[2*r], ay)) + SW'(mulq(r_m[2*r+1], by)));
                end
            end
            aff2d_pkg::OP_TRANS: begin
                n_m[4] = sat_w(SW'(r_m[4]) + SW'(ax));
                n_m[5] = sat_w(SW'(r_m[5]) + SW'(ay));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd_pop && is_point) begin
            n_out_valid = 1'b1;
            n_out.out_x = sat_32(SW'(px));
            n_out.out_y = sat_32(SW'(py));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_m[i] <= '0;
            end
            r_m[0] <= ONE_W;
            r_m[3] <= ONE_W;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_cmd_pop) begin
                r_m <= n_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
